// ----- rtl/core/rma_pkg.sv -----
package rma_pkg;

	// defaults for the top-level parameters
	localparam int WINDOW_MAX_DEF   = 256;
	localparam int SAMPLE_WIDTH_DEF = 32;

	// fixed field widths
	localparam int WINDOW_RESET = 16;
	localparam int CFG_W        = 9;
	localparam int AVG_W        = 32;
	localparam int WARMUP_W     = 9;
	localparam int IN_DATA_W    = 32;
	localparam int OUT_DATA_W   = 48;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 3;

	// register index (word address)
	localparam logic REG_WINDOW_SIZE = 1'b0;

	// input kind codes
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	typedef struct packed {
		logic clear;     // zero sum, position, count and result
		logic load;      // capture sample, read oldest entry
		logic update;    // new sum and count, write entry, start divide
		logic div_step;  // one quotient bit
		logic finish;    // apply sign to quotient
		logic out_load;  // move result into output register
	} rma_cmd_t;

	typedef struct packed {
		logic div_last;  // current divide step is the final one
		logic out_free;  // output register can take a result
	} rma_stat_t;

endpackage

// ----- rtl/core/rma_ram.sv -----
module rma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/rma_ctrl.sv -----
module rma_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tuser,
	output logic                s_tready,
	input  rma_pkg::rma_stat_t  stat,
	output rma_pkg::rma_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_FIN,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   accept;

	assign accept   = s_tvalid && (state_q == ST_IDLE);
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (s_tuser == rma_pkg::KIND_CLEAR) ? ST_RESULT : ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (stat.div_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.clear    = accept && (s_tuser == rma_pkg::KIND_CLEAR);
		cmd.load     = accept && (s_tuser == rma_pkg::KIND_SAMPLE);
		cmd.update   = (state_q == ST_READ);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_FIN);
		cmd.out_load = (state_q == ST_RESULT) && stat.out_free;
	end

endmodule

// ----- rtl/core/rma_dpath.sv -----
module rma_dpath #(
	parameter int WINDOW_MAX   = rma_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = rma_pkg::SAMPLE_WIDTH_DEF,
	parameter int CNT_W        = $clog2(WINDOW_MAX + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rma_pkg::rma_cmd_t             cmd,
	output rma_pkg::rma_stat_t            stat,
	input  logic                          cfg_we,
	input  logic [CNT_W-1:0]              cfg_window,
	output logic [CNT_W-1:0]              window,
	input  logic [SAMPLE_WIDTH-1:0]       sample,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rma_pkg::AVG_W-1:0]     average,
	output logic [rma_pkg::WARMUP_W-1:0]  warmup_left
);

	localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int WIN_RST = (rma_pkg::WINDOW_RESET > WINDOW_MAX) ?
		WINDOW_MAX : rma_pkg::WINDOW_RESET;

	logic [CNT_W-1:0]        window_q;
	logic [CNT_W-1:0]        fill_q;
	logic [ADDR_W-1:0]       pos_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SAMPLE_WIDTH-1:0] sample_q;

	// divider
	logic [SUM_W-1:0]        dvd_q;   // dividend in, quotient out
	logic [CNT_W-1:0]        rem_q;
	logic [CNT_W-1:0]        dsr_q;
	logic                    neg_q;
	logic [STEP_W-1:0]       step_q;

	logic                    out_valid_q;
	logic [rma_pkg::AVG_W-1:0]    avg_q;
	logic [rma_pkg::WARMUP_W-1:0] warm_q;

	logic [SAMPLE_WIDTH-1:0] old_entry;
	logic                    full;
	logic signed [SUM_W-1:0] new_sum;
	logic [CNT_W-1:0]        new_fill;
	logic [CNT_W-1:0]        pos_inc;
	logic [CNT_W:0]          rem_sh;
	logic                    q_bit;

	rma_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (WINDOW_MAX)
	) u_hist (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (pos_q),
		.wdata (sample_q),
		.re    (cmd.load),
		.raddr (pos_q),
		.rdata (old_entry)
	);

	assign full     = (fill_q >= window_q);
	assign new_sum  = sum_q + SUM_W'(signed'(sample_q))
		- (full ? SUM_W'(signed'(old_entry)) : '0);
	assign new_fill = full ? fill_q : fill_q + 1'b1;
	assign pos_inc  = CNT_W'(pos_q) + 1'b1;

	assign rem_sh = {rem_q, dvd_q[SUM_W-1]};
	assign q_bit  = (rem_sh >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= CNT_W'(WIN_RST);
			fill_q      <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_window;
			end
			if (cfg_we || cmd.clear) begin
				fill_q <= '0;
				pos_q  <= '0;
				sum_q  <= '0;
			end else if (cmd.update) begin
				fill_q <= new_fill;
				pos_q  <= (pos_inc == window_q) ? '0 : ADDR_W'(pos_inc);
				sum_q  <= new_sum;
			end
			if (cmd.update) begin
				step_q <= STEP_W'(SUM_W);
			end else if (cmd.div_step) begin
				step_q <= step_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
		end
		if (cmd.clear) begin
			dvd_q <= '0;
		end else if (cmd.update) begin
			neg_q <= new_sum[SUM_W-1];
			dvd_q <= new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
			rem_q <= '0;
			dsr_q <= new_fill;
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? CNT_W'(rem_sh - {1'b0, dsr_q}) : CNT_W'(rem_sh);
			dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
		end else if (cmd.finish) begin
			dvd_q <= neg_q ? SUM_W'(-dvd_q) : dvd_q;
		end
		if (cmd.out_load) begin
			avg_q  <= rma_pkg::AVG_W'(signed'(dvd_q));
			warm_q <= rma_pkg::WARMUP_W'(window_q - fill_q);
		end
	end

	assign stat.div_last = (step_q == STEP_W'(1));
	assign stat.out_free = !out_valid_q || m_tready;

	assign window      = window_q;
	assign m_tvalid    = out_valid_q;
	assign average     = avg_q;
	assign warmup_left = warm_q;

	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= window_q)
		else $error("fill count above window size");

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(pos_q) < window_q)
		else $error("write position outside window");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (dsr_q != '0))
		else $error("divide by zero count");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("result overwritten before taken");

endmodule

// ----- rtl/core/running_moving_average_core.sv -----
// Moving average over the last window_size signed samples.
// A sample item is captured on acceptance, then updates sum, count and history,
// runs the bit-serial divider (one quotient bit per cycle over the SUM_W-bit
// running sum), applies the sign and waits for a free output register; a clear
// item goes straight to that wait. No new item is taken until the result moves out.
// Reset (arst_n low, async): window_size = min(16, WINDOW_MAX), sum/position/count cleared.
module running_moving_average_core #(
	parameter int WINDOW_MAX   = rma_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = rma_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rma_pkg::IN_DATA_W-1:0]     s_tdata,   // [31:0] sample
	input  logic                              s_tuser,   // [0] kind (1 = clear)
	// result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rma_pkg::OUT_DATA_W-1:0]    m_tdata,   // [31:0] average, [40:32] warmup_left
	// config
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rma_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [rma_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [rma_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);

	rma_pkg::rma_cmd_t  cmd;
	rma_pkg::rma_stat_t stat;

	logic                         reg_sel;
	logic                         cfg_we;
	logic [rma_pkg::CFG_W-1:0]    wr_raw;
	logic [CNT_W-1:0]             cfg_window;
	logic [CNT_W-1:0]             window;
	logic [rma_pkg::AVG_W-1:0]    average;
	logic [rma_pkg::WARMUP_W-1:0] warmup_left;

	// APB: single register, word index in paddr[2], no wait states
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == rma_pkg::REG_WINDOW_SIZE);
	assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? rma_pkg::APB_DATA_W'(window) : '0;

	// window size clamps into 1..WINDOW_MAX before it is stored
	assign wr_raw = pwdata[rma_pkg::CFG_W-1:0];
	always_comb begin
		priority if (wr_raw == '0) begin
			cfg_window = CNT_W'(1);
		end else if (32'(wr_raw) > WINDOW_MAX) begin
			cfg_window = CNT_W'(WINDOW_MAX);
		end else begin
			cfg_window = CNT_W'(wr_raw);
		end
	end

	rma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// sample bits above SAMPLE_WIDTH are dropped; datapath sign-extends
	rma_dpath #(
		.WINDOW_MAX   (WINDOW_MAX),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.CNT_W        (CNT_W)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_window  (cfg_window),
		.window      (window),
		.sample      (s_tdata[SAMPLE_WIDTH-1:0]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.average     (average),
		.warmup_left (warmup_left)
	);

	assign m_tdata = {
		(rma_pkg::OUT_DATA_W - rma_pkg::AVG_W - rma_pkg::WARMUP_W)'(0),
		warmup_left,
		average
	};

endmodule
